// ----- rtl/dahq_pkg.sv -----
package dahq_pkg;
    localparam int CAPACITY  = 1024;
    localparam int MAX_ARITY = 8;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int KEY_W     = 32;
    localparam int ARITY_W   = 4;

    localparam logic [2:0] OP_INSERT   = 3'd0;
    localparam logic [2:0] OP_EXTRACT  = 3'd1;
    localparam logic [2:0] OP_INCREASE = 3'd2;
    localparam logic [2:0] OP_APPEND   = 3'd3;
    localparam logic [2:0] OP_BUILD    = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNDERFLOW = 3'd1;
    localparam logic [2:0] ST_SMALLER   = 3'd2;
    localparam logic [2:0] ST_OVERFLOW  = 3'd3;
    localparam logic [2:0] ST_RANGE     = 3'd4;

    // request to the shared index unit
    typedef struct packed {
        logic              start;
        logic              parent;   // 1: (i-1)/d, 0: d*i+1
        logic [CNT_W-1:0]  idx;
    } t_idx_req;

    typedef struct packed {
        logic              done;
        logic [CNT_W+3:0]  value;
    } t_idx_rsp;
endpackage

// ----- rtl/dahq_if.sv -----
interface dahq_in_if;
    import dahq_pkg::*;
    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    logic signed [31:0] key_value;
    logic [9:0]         position;
    modport source (output valid, operation, key_value, position, input ready);
    modport sink   (input valid, operation, key_value, position, output ready);
endinterface

interface dahq_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic [2:0]         status;
    logic [10:0]        entry_count;
    modport source (output valid, result_value, status, entry_count, input ready);
    modport sink   (input valid, result_value, status, entry_count, output ready);
endinterface

interface dahq_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/dahq_idx_unit.sv -----
// Shared index unit: d*i+1 by multiplication, (i-1)/d by restoring division
// one quotient bit per cycle.
module dahq_idx_unit import dahq_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [ARITY_W-1:0] i_arity,
    input  t_idx_req           i_req,
    output t_idx_rsp           o_rsp
);
    localparam int QW = CNT_W;
    localparam int CW = $clog2(QW + 1);

    logic              r_busy, n_busy;
    logic [QW-1:0]     r_quo, n_quo;
    logic [QW-1:0]     r_rem, n_rem;
    logic [QW-1:0]     r_num, n_num;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_done, n_done;
    logic [CNT_W+3:0]  r_val, n_val;
    logic [QW:0]       w_trial;

    assign w_trial = {r_rem, r_num[QW-1]} - {{(QW+1-ARITY_W){1'b0}}, i_arity};

    always_comb begin
        n_busy = r_busy; n_quo = r_quo; n_rem = r_rem; n_num = r_num;
        n_cnt = r_cnt; n_done = 1'b0; n_val = r_val;
        if (i_req.start) begin
            if (i_req.parent) begin
                n_busy = 1'b1;
                n_num  = i_req.idx - CNT_W'(1);
                n_rem  = '0;
                n_quo  = '0;
                n_cnt  = CW'(QW);
            end else begin
                n_done = 1'b1;
                n_val  = (CNT_W+4)'(i_req.idx) * (CNT_W+4)'(i_arity) + (CNT_W+4)'(1);
            end
        end else if (r_busy) begin
            if (!w_trial[QW]) begin
                n_rem = w_trial[QW-1:0];
                n_quo = {r_quo[QW-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[QW-2:0], r_num[QW-1]};
                n_quo = {r_quo[QW-2:0], 1'b0};
            end
            n_num = {r_num[QW-2:0], 1'b0};
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                n_val  = (CNT_W+4)'(n_quo);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_quo <= n_quo; r_rem <= n_rem; r_num <= n_num; r_cnt <= n_cnt; r_val <= n_val;
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_val;
endmodule

// ----- rtl/d_ary_max_heap_queue.sv -----
// Channel | Dir | Handshake   | Word
// in      | in  | valid/ready | operation, key_value, position
// out     | out | valid/ready | result_value, status, entry_count
// cfg     | in  | valid/ready | arity
// One word at a time. Insert/increase: each sift-up level runs the (i-1)/d
// divider of the index unit, then reads the parent. Extract: one store read
// per child per level. Build: divider, then the sum of sift-downs.
// Reset clears count and sets arity to 2; store contents stay undefined.
// The result holds in the output register until taken; no new word is
// accepted until then.
module d_ary_max_heap_queue import dahq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dahq_in_if.sink    in_ch,
    dahq_out_if.source out_ch,
    dahq_cfg_if.sink   cfg_ch
);
    typedef enum logic [4:0] {
        S_IDLE, S_RD_POS, S_CHK_POS, S_UP_DIV, S_UP_RDP, S_UP_WAIT, S_UP_CMP,
        S_DN_START, S_DN_MUL, S_DN_RDC, S_DN_WAIT, S_DN_CMP, S_DN_SWAP,
        S_BLD_DIV, S_BLD_NEXT, S_RD_ROOT, S_RD_ROOTW, S_RD_LAST, S_RD_LASTW,
        S_OUT
    } t_state;

    t_state               r_state;
    logic [KEY_W-1:0]     mem [CAPACITY];
    logic [KEY_W-1:0]     r_rdata;
    logic [ADDR_W-1:0]    r_raddr;
    logic                 r_we;
    logic [ADDR_W-1:0]    r_waddr;
    logic [KEY_W-1:0]     r_wdata;
    logic [CNT_W-1:0]     r_count;
    logic [ARITY_W-1:0]   r_arity;
    logic [2:0]           r_op;
    logic signed [31:0]   r_key;      // key being sifted
    logic [CNT_W-1:0]     r_i;        // current slot
    logic [CNT_W-1:0]     r_p;        // parent / best slot
    logic signed [31:0]   r_best;
    logic [CNT_W+3:0]     r_c;        // child slot
    logic [ARITY_W-1:0]   r_j;
    logic [CNT_W-1:0]     r_bi;       // build index
    logic signed [31:0]   r_res;
    logic [2:0]           r_st;
    t_idx_req             w_req;
    t_idx_rsp             w_rsp;
    logic [ARITY_W-1:0]   w_cfg_ar;

    dahq_idx_unit u_idx (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_arity(r_arity), .i_req(w_req), .o_rsp(w_rsp)
    );

    // store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (r_we) mem[r_waddr] <= r_wdata;
        r_rdata <= mem[r_raddr];
    end

    assign in_ch.ready  = (r_state == S_IDLE);
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = (r_state == S_OUT);
    assign out_ch.result_value = r_res;
    assign out_ch.status       = r_st;
    assign out_ch.entry_count  = r_count;

    // saturate arity into 1..MAX_ARITY
    always_comb begin
        w_cfg_ar = cfg_ch.data;
        if (w_cfg_ar == '0) w_cfg_ar = ARITY_W'(1);
        if (w_cfg_ar > ARITY_W'(MAX_ARITY)) w_cfg_ar = ARITY_W'(MAX_ARITY);
    end

    always_comb begin
        w_req = '0;
        unique case (r_state)
            S_UP_DIV: begin
                w_req.start = (r_i != '0) && !w_rsp.done && r_p == '1;
                w_req.parent = 1'b1;
                w_req.idx = r_i;
            end
            S_BLD_DIV: begin
                w_req.start = (r_p == '1) && !w_rsp.done;
                w_req.parent = 1'b1;
                w_req.idx = r_count;
            end
            S_DN_START: begin
                w_req.start = 1'b1;
                w_req.idx = r_i;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_arity <= ARITY_W'(2);
            r_we    <= 1'b0;
        end else begin
            r_we <= 1'b0;
            if (cfg_ch.valid && r_count == '0) r_arity <= w_cfg_ar;
            unique case (r_state)
                S_IDLE: if (in_ch.valid) begin
                    r_op  <= in_ch.operation;
                    r_key <= in_ch.key_value;
                    r_res <= '0;
                    r_st  <= ST_OK;
                    r_p   <= '1;
                    r_state <= S_OUT;
                    unique case (in_ch.operation)
                        OP_INSERT, OP_APPEND: begin
                            if (r_count >= CNT_W'(CAPACITY)) r_st <= ST_OVERFLOW;
                            else begin
                                r_we <= 1'b1;
                                r_waddr <= r_count[ADDR_W-1:0];
                                r_wdata <= in_ch.key_value;
                                r_count <= r_count + CNT_W'(1);
                                r_i <= r_count;
                                if (in_ch.operation == OP_INSERT) r_state <= S_UP_DIV;
                            end
                        end
                        OP_EXTRACT: begin
                            if (r_count == '0) r_st <= ST_UNDERFLOW;
                            else begin
                                r_raddr <= '0;
                                r_state <= S_RD_ROOT;
                            end
                        end
                        OP_INCREASE: begin
                            if (CNT_W'(in_ch.position) >= r_count) r_st <= ST_RANGE;
                            else begin
                                r_raddr <= ADDR_W'(in_ch.position);
                                r_i <= CNT_W'(in_ch.position);
                                r_state <= S_RD_POS;
                            end
                        end
                        OP_BUILD: if (r_count != '0) r_state <= S_BLD_DIV;
                        default: ;
                    endcase
                end
                S_RD_POS: r_state <= S_CHK_POS;
                S_CHK_POS: begin
                    if (r_key < $signed(r_rdata)) begin
                        r_st <= ST_SMALLER;
                        r_state <= S_OUT;
                    end else begin
                        r_we <= 1'b1;
                        r_waddr <= r_i[ADDR_W-1:0];
                        r_wdata <= r_key;
                        r_state <= S_UP_DIV;
                    end
                end
                // sift up: hold the key, move parents down
                S_UP_DIV: begin
                    if (r_i == '0) begin
                        r_we <= 1'b1;
                        r_waddr <= '0;
                        r_wdata <= r_key;
                        r_state <= S_OUT;
                    end else begin
                        if (w_rsp.done) begin
                            r_p <= w_rsp.value[CNT_W-1:0];
                            r_raddr <= w_rsp.value[ADDR_W-1:0];
                            r_state <= S_UP_RDP;
                        end else begin
                            r_p <= '0;
                        end
                    end
                end
                S_UP_RDP: r_state <= S_UP_WAIT;
                S_UP_WAIT: r_state <= S_UP_CMP;
                S_UP_CMP: begin
                    r_we <= 1'b1;
                    if ($signed(r_rdata) < r_key) begin
                        r_waddr <= r_i[ADDR_W-1:0];
                        r_wdata <= r_rdata;
                        r_i <= r_p;
                        r_p <= '1;
                        r_state <= S_UP_DIV;
                    end else begin
                        r_waddr <= r_i[ADDR_W-1:0];
                        r_wdata <= r_key;
                        r_state <= S_OUT;
                    end
                end
                S_RD_ROOT: r_state <= S_RD_ROOTW;
                S_RD_ROOTW: begin
                    r_res <= r_rdata;
                    r_count <= r_count - CNT_W'(1);
                    r_raddr <= ADDR_W'(r_count - CNT_W'(1));
                    r_state <= S_RD_LAST;
                end
                S_RD_LAST: r_state <= S_RD_LASTW;
                // build reuses the load path but keeps its own slot
                S_RD_LASTW: begin
                    r_key <= r_rdata;
                    r_i <= (r_op == OP_BUILD) ? r_bi : '0;
                    r_state <= S_DN_START;
                end
                // sift down: best of key and up to d children
                S_DN_START: begin
                    r_p <= r_i;
                    r_best <= r_key;
                    r_j <= ARITY_W'(1);
                    r_state <= S_DN_MUL;
                end
                S_DN_MUL: if (w_rsp.done) begin
                    r_c <= w_rsp.value;
                    r_state <= S_DN_RDC;
                end
                S_DN_RDC: begin
                    if (r_j > r_arity || r_c >= (CNT_W+4)'(r_count)) r_state <= S_DN_SWAP;
                    else begin
                        r_raddr <= r_c[ADDR_W-1:0];
                        r_state <= S_DN_WAIT;
                    end
                end
                S_DN_WAIT: r_state <= S_DN_CMP;
                S_DN_CMP: begin
                    if ($signed(r_rdata) > r_best) begin
                        r_best <= r_rdata;
                        r_p <= r_c[CNT_W-1:0];
                    end
                    r_c <= r_c + (CNT_W+4)'(1);
                    r_j <= r_j + ARITY_W'(1);
                    r_state <= S_DN_RDC;
                end
                S_DN_SWAP: begin
                    r_we <= 1'b1;
                    r_waddr <= r_i[ADDR_W-1:0];
                    if (r_p == r_i) begin
                        r_wdata <= r_key;
                        r_state <= (r_op == OP_BUILD) ? S_BLD_NEXT : S_OUT;
                    end else begin
                        r_wdata <= r_best;
                        r_i <= r_p;
                        r_state <= S_DN_START;
                    end
                end
                S_BLD_DIV: begin
                    r_p <= '0;
                    if (w_rsp.done) begin
                        r_bi <= w_rsp.value[CNT_W-1:0];
                        r_raddr <= w_rsp.value[ADDR_W-1:0];
                        r_i <= w_rsp.value[CNT_W-1:0];
                        r_state <= S_RD_LAST;
                        r_op <= OP_BUILD;
                    end
                end
                S_BLD_NEXT: begin
                    if (r_bi == '0) r_state <= S_OUT;
                    else begin
                        r_bi <= r_bi - CNT_W'(1);
                        r_raddr <= ADDR_W'(r_bi - CNT_W'(1));
                        r_state <= S_RD_LAST;
                    end
                end
                S_OUT: if (out_ch.ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
